// ===== hw/rtl/tcw_pkg.sv =====
// Shared widths and struct types for the transitive closure block.
// No dependencies; used by tcw_ram, tcw_engine and the top level.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int RowW   = 16;
    localparam int IdxW   = 4;
    localparam int SizeW  = 5;
    localparam int MaxRows = 16;

    typedef logic [RowW-1:0]  row_t;
    typedef logic [IdxW-1:0]  idx_t;
    typedef logic [SizeW-1:0] size_t;

    typedef struct packed {
        logic en;
        idx_t addr;
        row_t data;
    } ram_wr_t;

    typedef struct packed {
        logic en;
        idx_t addr;
    } ram_rd_t;

    typedef struct packed {
        logic compute;
        idx_t idx;
        row_t bits;
    } cmd_t;

endpackage

// ===== hw/rtl/transitive_closure_warshall_top.sv =====
// Top level of the Warshall transitive closure block: stream ports,
// size register and field packing. Uses tcw_pkg and tcw_engine.
`timescale 1ns / 1ps

// A load word (tuser 0) writes one row; rows at or above the size in use
// are dropped. A compute word (tuser 1) runs the closure over the row store,
// one read-modify-write per cycle: for each of the n pivots it reads the
// pivot row and then each row in turn; then every row is read and goes out
// through a read state and a wait state, which a stalled output can hold.
// The sweep is set by the single row store port pair. Rows must be loaded
// before compute; bits above the size come back zero. The user must write
// the size register only while the block is idle; it is not enforced.
module transitive_closure_warshall_top #(
    parameter int MAX_SIZE = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,     // matrix_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // row_index[3:0], row_bits[19:4], pad
    input  logic        s_tuser,      // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // out_row_index[3:0], out_row_bits[19:4], pad
    output logic        m_tlast
);

    localparam int Lim   = (MAX_SIZE < tcw_pkg::MaxRows) ? MAX_SIZE : tcw_pkg::MaxRows;
    localparam int Depth = Lim;

    tcw_pkg::size_t matrix_size_reg;
    tcw_pkg::size_t size_use;
    tcw_pkg::row_t  mask;
    tcw_pkg::cmd_t  cmd;
    tcw_pkg::idx_t  out_idx;
    tcw_pkg::row_t  out_bits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_size_reg <= tcw_pkg::size_t'(16);
        end else if (cfg_valid) begin
            matrix_size_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    always_comb begin
        if (matrix_size_reg == '0) begin
            size_use = tcw_pkg::size_t'(1);
        end else if (matrix_size_reg > tcw_pkg::size_t'(Lim)) begin
            size_use = tcw_pkg::size_t'(Lim);
        end else begin
            size_use = matrix_size_reg;
        end
    end

    assign mask = tcw_pkg::row_t'((32'd1 << size_use) - 32'd1);

    assign cmd.compute = s_tuser;
    assign cmd.idx     = s_tdata[3:0];
    assign cmd.bits    = s_tdata[19:4];

    tcw_engine #(.DEPTH(Depth)) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .size      (size_use),
        .mask      (mask),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_idx   (out_idx),
        .out_bits  (out_bits),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'b0000, out_bits, out_idx};

endmodule

// ===== hw/rtl/tcw_ram.sv =====
// Row store: one write port, one read port, registered read data.
// Same-cycle write to the read address is bypassed. Uses tcw_pkg.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  tcw_pkg::ram_wr_t wr,
    input  tcw_pkg::ram_rd_t rd,
    output tcw_pkg::row_t    rd_data
);

    tcw_pkg::row_t mem [DEPTH];
    tcw_pkg::row_t rd_reg;
    tcw_pkg::row_t byp_reg;
    logic          hit_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[AW'(wr.addr)] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_reg  <= mem[AW'(rd.addr)];
            hit_reg <= wr.en && (wr.addr == rd.addr);
            byp_reg <= wr.data;
        end
    end

    assign rd_data = hit_reg ? byp_reg : rd_reg;

endmodule

// ===== hw/rtl/tcw_engine.sv =====
// Closure sequencer: loads rows, runs the pivot/row read-modify-write
// sweep over tcw_ram and streams the result rows. Uses tcw_pkg, tcw_ram.
`timescale 1ns / 1ps

module tcw_engine #(
    parameter int DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcw_pkg::size_t       size,
    input  tcw_pkg::row_t        mask,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tcw_pkg::cmd_t        in_cmd,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tcw_pkg::idx_t        out_idx,
    output tcw_pkg::row_t        out_bits,
    output logic                 out_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_CLOSE   = 2'd1;
    localparam logic [1:0] ST_EMIT_RD = 2'd2;
    localparam logic [1:0] ST_EMIT_WT = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [AW-1:0]   z_reg, z_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [AW-1:0]   e_reg, e_next;
    logic            st_v_reg, st_v_next;
    logic            st_piv_reg, st_piv_next;
    logic [AW-1:0]   st_addr_reg, st_addr_next;
    tcw_pkg::row_t   pivot_reg, pivot_next;
    tcw_pkg::idx_t   pz_reg, pz_next;
    logic            ov_reg, ov_next;
    tcw_pkg::idx_t   oi_reg, oi_next;
    tcw_pkg::row_t   od_reg, od_next;
    logic            ol_reg, ol_next;

    tcw_pkg::ram_wr_t wr;
    tcw_pkg::ram_rd_t rd;
    tcw_pkg::row_t    rd_data;
    tcw_pkg::row_t    rd_m;
    tcw_pkg::size_t   last_idx;
    logic [AW-1:0]    rd_addr;

    tcw_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign rd_m     = rd_data & mask;
    assign last_idx = size - tcw_pkg::size_t'(1);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        z_next       = z_reg;
        i_next       = i_reg;
        e_next       = e_reg;
        st_v_next    = 1'b0;
        st_piv_next  = st_piv_reg;
        st_addr_next = st_addr_reg;
        pivot_next   = pivot_reg;
        pz_next      = pz_reg;
        ov_next      = ov_reg && !out_ready;
        oi_next      = oi_reg;
        od_next      = od_reg;
        ol_next      = ol_reg;
        rd_addr      = '0;
        rd.en        = 1'b0;
        rd.addr      = '0;
        wr.en        = 1'b0;
        wr.addr      = tcw_pkg::idx_t'(st_addr_reg);
        wr.data      = rd_m | (rd_m[pz_reg] ? pivot_reg : '0);

        // every row goes back masked so stray high bits are cleared
        if (st_v_reg) begin
            if (st_piv_reg) begin
                pivot_next = rd_m;
                pz_next    = tcw_pkg::idx_t'(st_addr_reg);
            end else begin
                wr.en = 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_cmd.compute) begin
                        z_next     = '0;
                        i_next     = '0;
                        state_next = ST_CLOSE;
                    end else if ({1'b0, in_cmd.idx} < size) begin
                        wr.en   = 1'b1;
                        wr.addr = in_cmd.idx;
                        wr.data = in_cmd.bits;
                    end
                end
            end
            ST_CLOSE: begin
                if (i_reg == '0) begin
                    rd_addr     = z_reg;
                    st_piv_next = 1'b1;
                end else begin
                    rd_addr     = AW'(i_reg - CW'(1));
                    st_piv_next = 1'b0;
                end
                rd.en        = 1'b1;
                rd.addr      = tcw_pkg::idx_t'(rd_addr);
                st_v_next    = 1'b1;
                st_addr_next = rd_addr;
                if (tcw_pkg::size_t'(i_reg) == size) begin
                    i_next = '0;
                    if (tcw_pkg::size_t'(z_reg) == last_idx) begin
                        e_next     = '0;
                        state_next = ST_EMIT_RD;
                    end else begin
                        z_next = z_reg + AW'(1);
                    end
                end else begin
                    i_next = i_reg + CW'(1);
                end
            end
            ST_EMIT_RD: begin
                rd.en      = 1'b1;
                rd.addr    = tcw_pkg::idx_t'(e_reg);
                state_next = ST_EMIT_WT;
            end
            ST_EMIT_WT: begin
                if (!ov_reg || out_ready) begin
                    ov_next = 1'b1;
                    oi_next = tcw_pkg::idx_t'(e_reg);
                    od_next = rd_m;
                    ol_next = (tcw_pkg::size_t'(e_reg) == last_idx);
                    if (tcw_pkg::size_t'(e_reg) == last_idx) begin
                        state_next = ST_IDLE;
                    end else begin
                        e_next     = e_reg + AW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            st_v_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            st_v_reg  <= st_v_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        z_reg       <= z_next;
        i_reg       <= i_next;
        e_reg       <= e_next;
        st_piv_reg  <= st_piv_next;
        st_addr_reg <= st_addr_next;
        pivot_reg   <= pivot_next;
        pz_reg      <= pz_next;
        oi_reg      <= oi_next;
        od_reg      <= od_next;
        ol_reg      <= ol_next;
    end

    assign out_valid = ov_reg;
    assign out_idx   = oi_reg;
    assign out_bits  = od_reg;
    assign out_last  = ol_reg;

`ifndef SYNTH
    a_stage_after_close: assert property (@(posedge aclk) disable iff (!aresetn)
        st_v_reg |-> $past(state_reg == ST_CLOSE))
        else $error("read stage valid without a closure read");

    a_pivot_after_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_v_reg && st_piv_reg) |-> $past(i_reg == '0))
        else $error("pivot capture not preceded by pivot read");

    a_no_write_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_WT) |-> !wr.en)
        else $error("row store written while emitting");

    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> (state_reg == ST_IDLE || st_v_reg))
        else $error("row store write without a load or closure stage");
`endif

endmodule

// ===== tb/transitive_closure_warshall_top_test.sv =====
// Self-checking test of transitive_closure_warshall_top: row loads, closure runs and size changes
// on the stream ports, checked word by word against an in-bench closure predictor.
// Depends on tcw_pkg and the RTL top level only.
`timescale 1ns / 1ps

module transitive_closure_warshall_top_test;

    localparam int DrainCycles = 400;
    localparam int CycleLimit  = 200000;
    localparam int RandItems   = 150;

    localparam logic CmdLoad    = 1'b0;
    localparam logic CmdCompute = 1'b1;

    localparam int StallNone   = 0;
    localparam int StallCoin   = 1;
    localparam int StallEvery4 = 2;
    localparam int StallLight  = 3;

    typedef struct packed {
        tcw_pkg::idx_t idx;
        tcw_pkg::row_t bits;
        logic          last;
    } closure_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    tcw_pkg::row_t               rel_rows [tcw_pkg::MaxRows];
    logic [tcw_pkg::MaxRows-1:0] row_loaded;
    int unsigned                 size_in_use;
    closure_row_t                expected_rows [$];

    int          errors      = 0;
    int unsigned cycle_count = 0;
    int          burst_left  = 0;
    int          stall_mode  = StallNone;
    int          stall_left  = 0;
    closure_row_t want;

    transitive_closure_warshall_top #(.MAX_SIZE(tcw_pkg::MaxRows)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                   input logic [31:0] got_val);
        $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, exp_val, got_val);
        errors++;
    endtask

    function automatic int unsigned clamp_size(input logic [4:0] v);
        if (v == 0) return 1;
        if (v > tcw_pkg::MaxRows) return tcw_pkg::MaxRows;
        return 32'(v);
    endfunction

    function automatic tcw_pkg::row_t random_row();
        case ($urandom_range(0, 3))
            0: return tcw_pkg::row_t'(1) << $urandom_range(0, tcw_pkg::RowW - 1);
            1: return tcw_pkg::row_t'($urandom & $urandom & $urandom);
            2: return tcw_pkg::row_t'($urandom);
            default: return '0;
        endcase
    endfunction

    // Closure predictor: runs on every accepted word, in acceptance order.
    task automatic predict_closure(input logic cmd, input tcw_pkg::idx_t idx,
                                   input tcw_pkg::row_t bits);
        int unsigned   n;
        tcw_pkg::row_t mask;
        closure_row_t  e;
        n = size_in_use;
        if (cmd == CmdLoad) begin
            if (idx < n) begin
                rel_rows[idx]   = bits;
                row_loaded[idx] = 1'b1;
            end
        end else begin
            mask = tcw_pkg::row_t'((32'd1 << n) - 32'd1);
            for (int x = 0; x < n; x++) rel_rows[x] &= mask;
            for (int z = 0; z < n; z++) begin
                for (int x = 0; x < n; x++) begin
                    if (rel_rows[x][z]) rel_rows[x] |= rel_rows[z];
                end
            end
            for (int x = 0; x < n; x++) begin
                e.idx  = tcw_pkg::idx_t'(x);
                e.bits = rel_rows[x];
                e.last = (x + 1 == n);
                expected_rows.push_back(e);
            end
        end
    endtask

    task automatic send_word(input logic cmd, input tcw_pkg::idx_t idx,
                             input tcw_pkg::row_t bits);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, bits, idx};
        do @(posedge aclk); while (!s_tready);
        predict_closure(cmd, idx, bits);
    endtask

    // Drop valid, drain all rows, then give a trailing load time to finish.
    task automatic settle_block();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (expected_rows.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_size(input logic [4:0] v);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        size_in_use = clamp_size(v);
    endtask

    // Output side: pattern-driven stalls and the in-order compare.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_rows.size() == 0) begin
                    report_mismatch("unexpected row word", 32'h0, {8'h0, m_tdata});
                end else begin
                    want = expected_rows.pop_front();
                    if (m_tdata[3:0] !== want.idx)
                        report_mismatch("row index", 32'(want.idx), 32'(m_tdata[3:0]));
                    if (m_tdata[19:4] !== want.bits)
                        report_mismatch("row bits", 32'(want.bits), 32'(m_tdata[19:4]));
                    if (m_tlast !== want.last)
                        report_mismatch("last flag", 32'(want.last), 32'(m_tlast));
                end
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(StallNone, StallLight);
                stall_left = $urandom_range(8, 64);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                StallNone:   m_tready <= 1'b1;
                StallCoin:   m_tready <= 1'($urandom_range(0, 1));
                StallEvery4: m_tready <= (cycle_count % 4) == 0;
                default:     m_tready <= $urandom_range(0, 3) != 0;
            endcase
        end
    end

    // Full size from reset: a chain 0->1->...->15, loaded from the top row down.
    task automatic test_chain_full_size();
        for (int i = tcw_pkg::MaxRows - 1; i >= 0; i--) begin
            send_word(CmdLoad, tcw_pkg::idx_t'(i),
                      (i < tcw_pkg::MaxRows - 1) ? tcw_pkg::row_t'(1) << (i + 1)
                                                 : tcw_pkg::row_t'(0));
        end
        send_word(CmdCompute, tcw_pkg::idx_t'(0), '0);
    endtask

    // Size zero acts as one; out-of-size load dropped; stray bits cleared;
    // repeated compute; oversize setting saturates.
    task automatic test_size_extremes();
        write_size(5'd0);
        send_word(CmdLoad, tcw_pkg::idx_t'(0), 16'hFFFF);
        send_word(CmdLoad, tcw_pkg::idx_t'(15), 16'hFFFF);
        send_word(CmdCompute, tcw_pkg::idx_t'(15), 16'hFFFF);
        send_word(CmdCompute, tcw_pkg::idx_t'(0), '0);
        write_size(5'd31);
        send_word(CmdCompute, tcw_pkg::idx_t'(9), 16'h5A5A);
    endtask

    task automatic test_random_phases();
        int          counted;
        int          rounds;
        int          n;
        int          cnt;
        int          j;
        int          tmp;
        int          order [tcw_pkg::MaxRows];
        logic [4:0]  plan [$];
        logic [4:0]  sz;
        counted = 0;
        plan = '{5'd1, 5'd16, 5'd2, 5'd17, 5'd0, 5'd3, 5'd31, 5'd8};
        while (counted < RandItems) begin
            sz = (plan.size() != 0) ? plan.pop_front() : 5'($urandom_range(0, 31));
            write_size(sz);
            n = size_in_use;
            rounds = $urandom_range(1, 3);
            for (int r = 0; r < rounds; r++) begin
                if (&row_loaded && $urandom_range(0, 1)) begin
                    cnt = $urandom_range(1, n);
                    for (int k = 0; k < cnt; k++) order[k] = $urandom_range(0, n - 1);
                end else begin
                    cnt = n;
                    for (int k = 0; k < n; k++) order[k] = k;
                    for (int k = n - 1; k > 0; k--) begin
                        j = $urandom_range(0, k);
                        tmp = order[k];
                        order[k] = order[j];
                        order[j] = tmp;
                    end
                end
                for (int k = 0; k < cnt; k++) begin
                    if (n < tcw_pkg::MaxRows && $urandom_range(0, 7) == 0)
                        send_word(CmdLoad,
                                  tcw_pkg::idx_t'($urandom_range(n, tcw_pkg::MaxRows - 1)),
                                  random_row());
                    send_word(CmdLoad, tcw_pkg::idx_t'(order[k]), random_row());
                    counted++;
                end
                send_word(CmdCompute, tcw_pkg::idx_t'($urandom_range(0, 15)),
                          tcw_pkg::row_t'($urandom));
                counted++;
                if ($urandom_range(0, 5) == 0) begin
                    send_word(CmdCompute, tcw_pkg::idx_t'($urandom_range(0, 15)),
                              tcw_pkg::row_t'($urandom));
                    counted++;
                end
            end
        end
    endtask

    initial begin
        size_in_use = tcw_pkg::MaxRows;
        row_loaded  = '0;
        for (int i = 0; i < tcw_pkg::MaxRows; i++) rel_rows[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_chain_full_size();
        test_size_extremes();
        test_random_phases();
        settle_block();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
